// ===== rtl/rhc_pkg.sv =====
// rhc_pkg: widths, constants and the item type shared by the colour converter
// modules. No dependencies.
package rhc_pkg;

  localparam int PIX_W         = 8;
  localparam int HUE_W         = 15;
  localparam int HUE_FRAC_BITS = 6;

  // full turn in hue units and the quotient width that can hold it
  localparam int HUE_FULL_INT = 360 * (2 ** HUE_FRAC_BITS);
  localparam int HUE_QW       = $clog2(HUE_FULL_INT + 1);

  // divisors are twice an 8-bit value
  localparam int DIV_DW = PIX_W + 1;
  localparam int HUE_AW = HUE_QW + DIV_DW;
  localparam int SAT_QW = PIX_W;
  localparam int SAT_AW = SAT_QW + DIV_DW;

  // 360 * 255 needs 17 bits
  localparam int NUMER_W = 17;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [HUE_QW-1:0] HUE_FULL = HUE_QW'(HUE_FULL_INT);

  // a_hue / a_sat start as the dividend and end as {remainder, quotient}
  typedef struct packed {
    logic [HUE_AW-1:0] a_hue;
    logic [DIV_DW-1:0] d_hue;
    logic [SAT_AW-1:0] a_sat;
    logic [DIV_DW-1:0] d_sat;
    logic              grey;
    logic              black;
    logic [PIX_W-1:0]  value;
  } rhc_item_t;

endpackage

// ===== rtl/rhc_front.sv =====
// rhc_front: takes a pixel transaction, finds max/min and the hue sector and
// registers the dividends and divisors for the back end. Uses rhc_pkg.
module rhc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rhc_pkg::PIX_W-1:0] green_in,
  input  logic [rhc_pkg::PIX_W-1:0] red_in,
  input  logic [rhc_pkg::PIX_W-1:0] blue_in,
  output logic                      push,
  input  logic                      fifo_full,
  output rhc_pkg::rhc_item_t        item
);
  import rhc_pkg::*;

  logic [PIX_W-1:0]   mx, mn, delta, diff;
  logic               red_max, green_max, diff_pos;
  logic [NUMER_W-1:0] base, numer, diff60;
  logic               item_vld;
  logic               ready;
  rhc_item_t          item_next;

  assign ready    = !item_vld || !fifo_full;
  assign in_stall = !ready;
  assign push     = item_vld && !fifo_full;

  always_comb begin
    mx = (red_in > green_in) ? red_in : green_in;
    if (blue_in > mx) mx = blue_in;
    mn = (red_in < green_in) ? red_in : green_in;
    if (blue_in < mn) mn = blue_in;
    delta = mx - mn;

    red_max   = (mx == red_in);
    green_max = !red_max && (mx == green_in);

    // sector offset and signed difference taken as sign and magnitude
    priority if (red_max) begin
      diff_pos = (green_in >= blue_in);
      diff     = diff_pos ? green_in - blue_in : blue_in - green_in;
      base     = diff_pos ? '0 : NUMER_W'(360) * NUMER_W'(delta);
    end else if (green_max) begin
      diff_pos = (blue_in >= red_in);
      diff     = diff_pos ? blue_in - red_in : red_in - blue_in;
      base     = NUMER_W'(120) * NUMER_W'(delta);
    end else begin
      diff_pos = (red_in >= green_in);
      diff     = diff_pos ? red_in - green_in : green_in - red_in;
      base     = NUMER_W'(240) * NUMER_W'(delta);
    end

    diff60 = NUMER_W'(60) * NUMER_W'(diff);
    numer  = diff_pos ? base + diff60 : base - diff60;

    // round to nearest: (2*numer*2^F + delta) / (2*delta)
    item_next.a_hue = (HUE_AW'(numer) << (HUE_FRAC_BITS + 1)) + HUE_AW'(delta);
    item_next.d_hue = {delta, 1'b0};
    item_next.a_sat = SAT_AW'(510) * SAT_AW'(delta) + SAT_AW'(mx);
    item_next.d_sat = {mx, 1'b0};
    item_next.grey  = (delta == '0);
    item_next.black = (mx == '0);
    item_next.value = mx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (ready) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

// ===== rtl/rhc_fifo.sv =====
// rhc_fifo: short queue between front and back end, first-word fall-through.
// Uses rhc_pkg for the item type and depth.
module rhc_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rhc_pkg::rhc_item_t wr_data,
  output logic               full,
  input  logic               pop,
  output rhc_pkg::rhc_item_t rd_data,
  output logic               empty
);
  import rhc_pkg::*;

  rhc_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;

  assign full    = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_bad_push: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_bad_pop: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// ===== rtl/rhc_back.sv =====
// rhc_back: pipelined restoring dividers for hue and saturation, one quotient
// bit per stage, then wrap and output register. Uses rhc_pkg.
module rhc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  rhc_pkg::rhc_item_t        rd_data,
  input  logic                      empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rhc_pkg::HUE_W-1:0] hue_out,
  output logic [rhc_pkg::PIX_W-1:0] saturation_out,
  output logic [rhc_pkg::PIX_W-1:0] value_out
);
  import rhc_pkg::*;

  function automatic logic [HUE_AW-1:0] hue_step(input logic [HUE_AW-1:0] a,
                                                 input logic [DIV_DW-1:0] d);
    logic [DIV_DW:0] r;
    logic [DIV_DW:0] s;
    r = a[HUE_AW-1 -: DIV_DW+1];
    s = r - {1'b0, d};
    if (r >= {1'b0, d}) return {s[DIV_DW-1:0], a[HUE_QW-2:0], 1'b1};
    else                return {r[DIV_DW-1:0], a[HUE_QW-2:0], 1'b0};
  endfunction

  function automatic logic [SAT_AW-1:0] sat_step(input logic [SAT_AW-1:0] a,
                                                 input logic [DIV_DW-1:0] d);
    logic [DIV_DW:0] r;
    logic [DIV_DW:0] s;
    r = a[SAT_AW-1 -: DIV_DW+1];
    s = r - {1'b0, d};
    if (r >= {1'b0, d}) return {s[DIV_DW-1:0], a[SAT_QW-2:0], 1'b1};
    else                return {r[DIV_DW-1:0], a[SAT_QW-2:0], 1'b0};
  endfunction

  rhc_item_t         pipe_q  [HUE_QW+1];
  rhc_item_t         stage_nx[HUE_QW];
  logic [HUE_QW:0]   pipe_vld;
  logic              en;
  logic [HUE_QW-1:0] quot, hue_wrap;
  rhc_item_t         last;

  // whole pipe moves unless a finished transaction is held at the output
  assign en  = !(out_valid && out_stall);
  assign pop = en && !empty;

  always_comb begin
    for (int k = 0; k < HUE_QW; k++) begin
      stage_nx[k]       = pipe_q[k];
      stage_nx[k].a_hue = hue_step(pipe_q[k].a_hue, pipe_q[k].d_hue);
      if (k < SAT_QW) begin
        stage_nx[k].a_sat = sat_step(pipe_q[k].a_sat, pipe_q[k].d_sat);
      end
    end
  end

  assign last     = pipe_q[HUE_QW];
  assign quot     = last.a_hue[HUE_QW-1:0];
  assign hue_wrap = (quot >= HUE_FULL) ? quot - HUE_FULL : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_vld  <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      pipe_vld  <= {pipe_vld[HUE_QW-1:0], !empty};
      out_valid <= pipe_vld[HUE_QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_q[0] <= rd_data;
      for (int k = 0; k < HUE_QW; k++) begin
        pipe_q[k+1] <= stage_nx[k];
      end
      hue_out        <= last.grey  ? '0 : HUE_W'(hue_wrap);
      saturation_out <= last.black ? '0 : last.a_sat[SAT_QW-1:0];
      value_out      <= last.value;
    end
  end

  a_black_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (value_out == '0) |-> (hue_out == '0) && (saturation_out == '0))
    else $error("black pixel with non-zero hue or saturation");

  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    en && pipe_vld[HUE_QW] && last.grey |=> out_valid && (hue_out == '0))
    else $error("grey pixel with non-zero hue");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> out_valid)
    else $error("held transaction dropped");

endmodule

// ===== rtl/rgb_to_hsv_converter_top.sv =====
// rgb_to_hsv_converter_top: the hue is computed by a one-bit-per-stage divider
// with 6 hue fraction bits, HUE_QW quotient bits in all.
// Throughput is one pixel transaction per cycle when the output is not stalled.
// The front end, a 4-entry queue and the divider pipe stall independently.
// Synchronous active-high reset empties every stage and the queue; no clearing
// pass is needed. Depends on rhc_pkg, rhc_front, rhc_fifo and rhc_back.
module rgb_to_hsv_converter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rhc_pkg::PIX_W-1:0] green_in,
  input  logic [rhc_pkg::PIX_W-1:0] red_in,
  input  logic [rhc_pkg::PIX_W-1:0] blue_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rhc_pkg::HUE_W-1:0] hue_out,
  output logic [rhc_pkg::PIX_W-1:0] saturation_out,
  output logic [rhc_pkg::PIX_W-1:0] value_out
);
  import rhc_pkg::*;

  rhc_item_t fe_item, q_item;
  logic      push, full, pop, empty;

  rhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .green_in  (green_in),
    .red_in    (red_in),
    .blue_in   (blue_in),
    .push      (push),
    .fifo_full (full),
    .item      (fe_item)
  );

  rhc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (fe_item),
    .full    (full),
    .pop     (pop),
    .rd_data (q_item),
    .empty   (empty)
  );

  rhc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .rd_data        (q_item),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hue_out        (hue_out),
    .saturation_out (saturation_out),
    .value_out      (value_out)
  );

endmodule

// ===== dv/tb_rgb_to_hsv_converter_top.sv =====
// tb_rgb_to_hsv_converter_top: self-checking testbench for the rgb to hsv converter,
// with a scoreboard class that predicts hue, saturation and value per pixel.
// Depends on rhc_pkg and rgb_to_hsv_converter_top.
module tb_rgb_to_hsv_converter_top;

  import rhc_pkg::*;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    pix_t             sat;
    pix_t             val;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t pending_hsv[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function hsv_t convert_pixel(pix_t g, pix_t r, pix_t b);
      hsv_t            res;
      int unsigned     gi, ri, bi, mx, mn, delta, sat;
      longint unsigned numer, q, full;
      gi = g;
      ri = r;
      bi = b;
      full = 360 * (longint'(1) << HUE_FRAC_BITS);
      mx = (ri > gi) ? ri : gi;
      if (bi > mx) mx = bi;
      mn = (ri < gi) ? ri : gi;
      if (bi < mn) mn = bi;
      delta = mx - mn;
      if (mx == 0) sat = 0;
      else sat = (510 * delta + mx) / (2 * mx);
      if (delta == 0) begin
        q = 0;
      end else begin
        // sector priority: red, then green, then blue
        if (mx == ri) begin
          if (gi >= bi) numer = 60 * (gi - bi);
          else numer = 360 * delta - 60 * (bi - gi);
        end else if (mx == gi) begin
          if (bi >= ri) numer = 120 * delta + 60 * (bi - ri);
          else numer = 120 * delta - 60 * (ri - bi);
        end else begin
          if (ri >= gi) numer = 240 * delta + 60 * (ri - gi);
          else numer = 240 * delta - 60 * (gi - ri);
        end
        numer = numer << HUE_FRAC_BITS;
        q = (2 * numer + delta) / (2 * longint'(delta));
        if (q >= full) q = q - full;
      end
      res.hue = HUE_W'(q);
      res.sat = PIX_W'(sat);
      res.val = PIX_W'(mx);
      return res;
    endfunction

    function void note_pixel(pix_t g, pix_t r, pix_t b);
      pending_hsv.push_back(convert_pixel(g, r, b));
    endfunction

    function void check_result(logic [HUE_W-1:0] hue, pix_t sat, pix_t val);
      hsv_t exp_hsv;
      if (pending_hsv.size() == 0) begin
        $display("%0t: unexpected result hue %0d sat %0d val %0d", $time, hue, sat, val);
        errors++;
        return;
      end
      exp_hsv = pending_hsv.pop_front();
      if (hue !== exp_hsv.hue) begin
        $display("%0t: hue expected %0d actual %0d", $time, exp_hsv.hue, hue);
        errors++;
      end
      if (sat !== exp_hsv.sat) begin
        $display("%0t: saturation expected %0d actual %0d", $time, exp_hsv.sat, sat);
        errors++;
      end
      if (val !== exp_hsv.val) begin
        $display("%0t: value expected %0d actual %0d", $time, exp_hsv.val, val);
        errors++;
      end
    endfunction

    function int pending();
      return pending_hsv.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  pix_t             green_in;
  pix_t             red_in;
  pix_t             blue_in;
  logic             out_valid;
  logic             out_stall;
  logic [HUE_W-1:0] hue_out;
  pix_t             saturation_out;
  pix_t             value_out;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  hsv_scoreboard board;

  rgb_to_hsv_converter_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .green_in       (green_in),
    .red_in         (red_in),
    .blue_in        (blue_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hue_out        (hue_out),
    .saturation_out (saturation_out),
    .value_out      (value_out)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // entered just after a falling edge, returns just after a falling edge
  task automatic send_pixel(pix_t g, pix_t r, pix_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      green_in = pix_t'($urandom);
      red_in   = pix_t'($urandom);
      blue_in  = pix_t'($urandom);
      @(negedge clk);
    end
    in_valid = 1'b1;
    green_in = g;
    red_in   = r;
    blue_in  = b;
    do @(posedge clk); while (in_stall);
    board.note_pixel(g, r, b);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (board.pending() > 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    pix_t        g, r, b, hi;
    int unsigned kind;
    g    = pix_t'($urandom);
    r    = pix_t'($urandom);
    b    = pix_t'($urandom);
    hi   = pix_t'($urandom);
    kind = $urandom_range(99);
    if (kind < 15) begin
      // grey
      g = hi;
      r = hi;
      b = hi;
    end else if (kind < 30) begin
      // tie for the maximum between two components
      case ($urandom_range(2))
        0: begin g = hi; r = hi; end
        1: begin r = hi; b = hi; end
        default: begin g = hi; b = hi; end
      endcase
    end else if (kind < 45) begin
      // one component pinned at an extreme
      case ($urandom_range(2))
        0: g = $urandom_range(1) ? 8'hff : 8'h00;
        1: r = $urandom_range(1) ? 8'hff : 8'h00;
        default: b = $urandom_range(1) ? 8'hff : 8'h00;
      endcase
    end else if (kind < 55) begin
      // small delta near the maximum
      g = hi - pix_t'($urandom_range(3));
      r = hi - pix_t'($urandom_range(3));
      b = hi - pix_t'($urandom_range(3));
    end
    send_pixel(g, r, b);
  endtask

  task automatic run_phase(int unsigned snd_pct, int unsigned rcv_pct, int n);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (n) send_random_pixel();
    drain_results();
  endtask

  // receiver back-pressure
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.check_result(hue_out, saturation_out, value_out);
    end
  end

  initial begin
    board         = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    green_in      = '0;
    red_in        = '0;
    blue_in       = '0;
    send_idle_pct = 31;
    recv_idle_pct = 80;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed pixels, order is green, red, blue
    send_pixel(8'h00, 8'h00, 8'h00);   // black
    send_pixel(8'hff, 8'hff, 8'hff);   // white grey
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'h00, 8'hff, 8'h00);   // pure red
    send_pixel(8'hff, 8'h00, 8'h00);   // pure green
    send_pixel(8'h00, 8'h00, 8'hff);   // pure blue
    send_pixel(8'hff, 8'hff, 8'h00);   // red and green tie
    send_pixel(8'h00, 8'hff, 8'hff);   // red and blue tie
    send_pixel(8'hff, 8'h00, 8'hff);   // green and blue tie
    send_pixel(8'h00, 8'hff, 8'h01);   // red sector, hue just under a full turn
    send_pixel(8'h01, 8'hff, 8'h00);
    send_pixel(8'hfe, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hfe, 8'hff);
    send_pixel(8'hff, 8'hff, 8'hfe);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h01, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'h7f, 8'h80, 8'h81);
    send_pixel(8'h55, 8'haa, 8'hff);
    send_pixel(8'haa, 8'h55, 8'h00);
    send_pixel(8'h03, 8'h02, 8'h01);
    drain_results();

    run_phase(31, 80, 260);
    run_phase(80, 31, 260);
    run_phase(0, 0, 260);

    repeat (HUE_QW + 40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_rgb_to_hsv_converter_top: done, clean");
    end else begin
      $display("tb_rgb_to_hsv_converter_top: done, errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_rgb_to_hsv_converter_top: done, errors");
    $finish;
  end

endmodule
